// File: rtl/stable_priority_queue_core_defines.svh
// Assertion macros shared by the stable priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg)

`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
package spq_pkg;

  localparam int unsigned PRIO_BITS        = 8;
  localparam int unsigned PAYLOAD_OUT_BITS = 32;
  localparam int unsigned STATUS_BITS      = 2;
  localparam int unsigned FILL_BITS        = 5;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 2'd2;

  // Broadcast to every cell in the chain for one transaction.
  typedef struct packed {
    logic                 enq;
    logic                 deq;
    logic [PRIO_BITS-1:0] prio;
  } spq_ctrl_t;

endpackage

// File: rtl/stable_priority_queue_core.sv
// Stable sorted priority queue built as a chain of shifting cells.
//
//  channel | direction | handshake            | payload
//  in      | sink      | in_valid_i/in_ready_o | func_i, prio_i, payload_in_i
//  out     | source    | out_valid_o/out_ready_i | payload_out_o, status_o, empty_res_o, fill_o
//
// Every cell compares its priority with the incoming one in parallel and the whole
// chain shifts in the same cycle, so one transaction is taken per cycle unless the input is stalled.
// The result is registered on acceptance and shown from the next cycle.
// Input is stalled only while a result waits and out_ready_i is low.
// Reset clears the entry count and the output valid; cell contents are not reset.

`include "stable_priority_queue_core_defines.svh"

module stable_priority_queue_core #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    func_i,
  input  logic [spq_pkg::PRIO_BITS-1:0]           prio_i,
  input  logic [spq_pkg::PAYLOAD_OUT_BITS-1:0]    payload_in_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [spq_pkg::PAYLOAD_OUT_BITS-1:0]    payload_out_o,
  output logic [spq_pkg::STATUS_BITS-1:0]         status_o,
  output logic                                    empty_res_o,
  output logic [spq_pkg::FILL_BITS-1:0]           fill_o
);

  localparam int unsigned OccBits = $clog2(DEPTH + 1);

  logic [OccBits-1:0] occ_q, occ_d;
  logic               out_valid_q;

  logic [spq_pkg::PAYLOAD_OUT_BITS-1:0] payload_out_q, payload_out_d;
  logic [spq_pkg::STATUS_BITS-1:0]      status_q, status_d;
  logic                                 empty_q, empty_d;
  logic [spq_pkg::FILL_BITS-1:0]        fill_q, fill_d;

  logic accept, is_enq, full, empty, do_enq, do_deq;
  spq_pkg::spq_ctrl_t ctrl;
  logic [PAYLOAD_BITS-1:0] new_payload;

  logic [DEPTH-1:0]                  ins_w;
  logic [spq_pkg::PRIO_BITS-1:0]     prio_w    [DEPTH];
  logic [PAYLOAD_BITS-1:0]           payload_w [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_enq     = (func_i == spq_pkg::FUNC_ENQ);
  assign full       = (occ_q == OccBits'(DEPTH));
  assign empty      = (occ_q == '0);
  assign do_enq     = accept && is_enq && !full;
  assign do_deq     = accept && !is_enq && !empty;

  assign ctrl.enq    = do_enq;
  assign ctrl.deq    = do_deq;
  assign ctrl.prio   = prio_i;
  assign new_payload = PAYLOAD_BITS'(payload_in_i);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                          left_ins;
    logic [spq_pkg::PRIO_BITS-1:0] left_prio, right_prio;
    logic [PAYLOAD_BITS-1:0]       left_payload, right_payload;

    if (i == 0) begin : g_head
      assign left_ins     = 1'b0;
      assign left_prio    = '0;
      assign left_payload = '0;
    end else begin : g_body
      assign left_ins     = ins_w[i-1];
      assign left_prio    = prio_w[i-1];
      assign left_payload = payload_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_prio    = '0;
      assign right_payload = '0;
    end else begin : g_mid
      assign right_prio    = prio_w[i+1];
      assign right_payload = payload_w[i+1];
    end

    spq_cell #(
      .PayloadBits (PAYLOAD_BITS)
    ) u_cell (
      .clk_i           (clk_i),
      .ctrl_i          (ctrl),
      .occupied_i      (occ_q > OccBits'(i)),
      .new_payload_i   (new_payload),
      .left_ins_i      (left_ins),
      .left_prio_i     (left_prio),
      .left_payload_i  (left_payload),
      .right_prio_i    (right_prio),
      .right_payload_i (right_payload),
      .ins_o           (ins_w[i]),
      .prio_o          (prio_w[i]),
      .payload_o       (payload_w[i])
    );
  end

  always_comb begin
    occ_d         = occ_q;
    payload_out_d = '0;
    status_d      = spq_pkg::ST_OK;
    priority if (do_enq) begin
      occ_d = occ_q + 1'b1;
    end else if (do_deq) begin
      occ_d         = occ_q - 1'b1;
      payload_out_d = spq_pkg::PAYLOAD_OUT_BITS'(payload_w[0]);
    end else if (is_enq) begin
      status_d = spq_pkg::ST_OVERFLOW;
    end else begin
      status_d = spq_pkg::ST_UNDERFLOW;
    end
    empty_d = (occ_d == '0);
    fill_d  = spq_pkg::FILL_BITS'(occ_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        occ_q <= occ_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      payload_out_q <= payload_out_d;
      status_q      <= status_d;
      empty_q       <= empty_d;
      fill_q        <= fill_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign payload_out_o = payload_out_q;
  assign status_o      = status_q;
  assign empty_res_o   = empty_q;
  assign fill_o        = fill_q;

  `SPQ_ASSERT(a_occ_bound, clk_i, rst_ni, occ_q <= OccBits'(DEPTH), "entry count above depth")
  `SPQ_ASSERT(a_enq_grows, clk_i, rst_ni, do_enq |=> occ_q == $past(occ_q) + 1'b1,
              "enqueue did not add one entry")
  `SPQ_ASSERT(a_deq_shrinks, clk_i, rst_ni, do_deq |=> occ_q == $past(occ_q) - 1'b1,
              "dequeue did not remove one entry")
  `SPQ_ASSERT(a_ins_monotone, clk_i, rst_ni, (ins_w[DEPTH-2:0] & ~ins_w[DEPTH-1:1]) == '0,
              "insert flags not monotone along the chain")
  `SPQ_ASSERT(a_underflow_empty, clk_i, rst_ni,
              out_valid_q && status_q == spq_pkg::ST_UNDERFLOW |-> empty_q,
              "underflow reported on a non-empty queue")

endmodule

// File: rtl/spq_cell.sv
// One slot of the sorted chain: holds a priority and a payload, shifts with its neighbors.
module spq_cell #(
  parameter int unsigned PayloadBits = 32
) (
  input  logic                            clk_i,
  input  spq_pkg::spq_ctrl_t              ctrl_i,
  input  logic                            occupied_i,
  input  logic [PayloadBits-1:0]          new_payload_i,
  input  logic                            left_ins_i,
  input  logic [spq_pkg::PRIO_BITS-1:0]   left_prio_i,
  input  logic [PayloadBits-1:0]          left_payload_i,
  input  logic [spq_pkg::PRIO_BITS-1:0]   right_prio_i,
  input  logic [PayloadBits-1:0]          right_payload_i,
  output logic                            ins_o,
  output logic [spq_pkg::PRIO_BITS-1:0]   prio_o,
  output logic [PayloadBits-1:0]          payload_o
);

  logic [spq_pkg::PRIO_BITS-1:0] prio_q;
  logic [PayloadBits-1:0]        payload_q;

  // Empty slot or strictly larger priority: the new entry lands here or further left.
  assign ins_o = !occupied_i || (prio_q > ctrl_i.prio);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.enq) begin
      if (left_ins_i) begin
        prio_q    <= left_prio_i;
        payload_q <= left_payload_i;
      end else if (ins_o) begin
        prio_q    <= ctrl_i.prio;
        payload_q <= new_payload_i;
      end
    end else if (ctrl_i.deq) begin
      prio_q    <= right_prio_i;
      payload_q <= right_payload_i;
    end
  end

  assign prio_o    = prio_q;
  assign payload_o = payload_q;

endmodule

// File: tb/tb_stable_priority_queue_core.sv
// Self-checking testbench for the stable sorted priority queue core.
`timescale 1ns / 100ps

module tb_stable_priority_queue_core;

  localparam int unsigned QDEPTH       = 16;
  localparam int unsigned PAYLOAD_W    = 32;
  localparam int unsigned LONG_HOLD    = 60;
  localparam int unsigned RAND_OPS     = 500;
  localparam int unsigned CHUNK_OPS    = 40;
  localparam int unsigned SETTLE_CYC   = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic                                 func;
    logic [spq_pkg::PRIO_BITS-1:0]        prio;
    logic [spq_pkg::PAYLOAD_OUT_BITS-1:0] payload;
  } queue_op_t;

  typedef struct packed {
    logic [spq_pkg::PAYLOAD_OUT_BITS-1:0] payload;
    logic [spq_pkg::STATUS_BITS-1:0]      status;
    logic                                 empty;
    logic [spq_pkg::FILL_BITS-1:0]        fill;
  } qresult_t;

  typedef struct {
    logic [spq_pkg::PRIO_BITS-1:0] prio;
    logic [PAYLOAD_W-1:0]          handle;
  } held_entry_t;

  // Tracks the sorted queue contents and the results still owed by the block.
  class queue_tracker;
    held_entry_t held[$];
    qresult_t    owed[$];
    int unsigned errors;

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void note_op(queue_op_t op);
      qresult_t    r;
      held_entry_t ent;
      int unsigned pos;
      r.payload = '0;
      r.status  = spq_pkg::ST_OK;
      if (op.func == spq_pkg::FUNC_ENQ) begin
        if (held.size() >= QDEPTH) begin
          r.status = spq_pkg::ST_OVERFLOW;
        end else begin
          // stable insert: goes behind every entry of lower or equal priority
          pos = 0;
          while (pos < held.size() && held[pos].prio <= op.prio) pos++;
          ent.prio   = op.prio;
          ent.handle = op.payload;
          held.insert(pos, ent);
        end
      end else if (held.size() == 0) begin
        r.status = spq_pkg::ST_UNDERFLOW;
      end else begin
        r.payload = held[0].handle;
        held.delete(0);
      end
      r.empty = (held.size() == 0);
      r.fill  = spq_pkg::FILL_BITS'(held.size());
      owed.push_back(r);
    endfunction

    task check_result(qresult_t got);
      qresult_t want;
      if (owed.size() == 0) begin
        report($sformatf("result with none owed: payload %h status %0d empty %0b fill %0d",
                         got.payload, got.status, got.empty, got.fill));
        return;
      end
      want = owed.pop_front();
      if (got.payload !== want.payload)
        report($sformatf("payload_out got %h want %h", got.payload, want.payload));
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.empty !== want.empty)
        report($sformatf("empty_res got %0b want %0b", got.empty, want.empty));
      if (got.fill !== want.fill)
        report($sformatf("fill got %0d want %0d", got.fill, want.fill));
    endtask
  endclass

  logic                                 clk_i        = 1'b0;
  logic                                 rst_ni       = 1'b0;
  logic                                 in_valid_i   = 1'b0;
  logic                                 in_ready_o;
  logic                                 func_i       = spq_pkg::FUNC_ENQ;
  logic [spq_pkg::PRIO_BITS-1:0]        prio_i       = '0;
  logic [spq_pkg::PAYLOAD_OUT_BITS-1:0] payload_in_i = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i  = 1'b0;
  logic [spq_pkg::PAYLOAD_OUT_BITS-1:0] payload_out_o;
  logic [spq_pkg::STATUS_BITS-1:0]      status_o;
  logic                                 empty_res_o;
  logic [spq_pkg::FILL_BITS-1:0]        fill_o;

  queue_tracker tracker;
  logic         long_hold_req = 1'b0;
  logic         steady_mode   = 1'b0;
  int unsigned  cycle_count   = 0;

  stable_priority_queue_core #(
    .DEPTH       (QDEPTH),
    .PAYLOAD_BITS(PAYLOAD_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .prio_i       (prio_i),
    .payload_in_i (payload_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .payload_out_o(payload_out_o),
    .status_o     (status_o),
    .empty_res_o  (empty_res_o),
    .fill_o       (fill_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_stable_priority_queue_core: FAIL");
      $finish;
    end
  end

  // Both channels are sampled on the pre-edge values of the same clock edge.
  always @(posedge clk_i) begin : monitor
    queue_op_t seen_op;
    qresult_t  seen_res;
    if (rst_ni) begin
      if (in_valid_i === 1'b1 && in_ready_o === 1'b1) begin
        seen_op = '{func: func_i, prio: prio_i, payload: payload_in_i};
        tracker.note_op(seen_op);
      end
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        seen_res = '{payload: payload_out_o, status: status_o, empty: empty_res_o,
                     fill: fill_o};
        tracker.check_result(seen_res);
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  initial begin : sink_side
    int unsigned span;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (steady_mode || $urandom_range(99) < 70) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        span = pick_gap();
        out_ready_i <= 1'b0;
        repeat (span) @(posedge clk_i);
      end
    end
  end

  // Offers one transaction, holds it until taken, then maybe idles.
  task automatic send_op(input logic func, input logic [spq_pkg::PRIO_BITS-1:0] prio,
                         input logic [spq_pkg::PAYLOAD_OUT_BITS-1:0] payload);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    func_i       <= func;
    prio_i       <= prio;
    payload_in_i <= payload;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    gap = (steady_mode || $urandom_range(99) < 60) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.owed.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [spq_pkg::PRIO_BITS-1:0] pick_prio();
    // narrow range half the time so equal priorities pile up
    if ($urandom_range(1) == 0) return spq_pkg::PRIO_BITS'($urandom_range(3));
    return spq_pkg::PRIO_BITS'($urandom_range(255));
  endfunction

  function automatic logic [spq_pkg::PAYLOAD_OUT_BITS-1:0] pick_payload();
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  localparam logic [spq_pkg::PRIO_BITS-1:0] DIR_PRIO [QDEPTH] = '{
    8'd255, 8'd0, 8'd7, 8'd7, 8'd0, 8'd255, 8'd7, 8'd128,
    8'd1, 8'd254, 8'd7, 8'd0, 8'd64, 8'd64, 8'd200, 8'd3
  };

  initial begin : stimulus
    int unsigned chunk;
    int unsigned enq_pct;
    int unsigned k;
    logic [spq_pkg::PAYLOAD_OUT_BITS-1:0] handle;
    tracker = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // dequeue on empty queue
    send_op(spq_pkg::FUNC_DEQ, 8'hA5, '1);
    // fill to the top with ties and both priority extremes
    for (k = 0; k < QDEPTH; k++) begin
      handle = (k == 0) ? '0 : (k == 1) ? '1 : 32'h5A00_0000 + k;
      send_op(spq_pkg::FUNC_ENQ, DIR_PRIO[k], handle);
    end
    // full queue drops entries
    send_op(spq_pkg::FUNC_ENQ, 8'd0, 32'hFFFF_0000);
    send_op(spq_pkg::FUNC_ENQ, 8'd255, 32'h0000_FFFF);
    // prio is ignored on dequeue
    send_op(spq_pkg::FUNC_DEQ, 8'd0, '0);
    send_op(spq_pkg::FUNC_DEQ, 8'd255, '1);
    for (k = 0; k < 3; k++) send_op(spq_pkg::FUNC_DEQ, pick_prio(), pick_payload());

    for (chunk = 0; chunk * CHUNK_OPS < RAND_OPS; chunk++) begin
      case (chunk % 4)
        0:       enq_pct = 85;
        1:       enq_pct = 15;
        2:       enq_pct = 50;
        default: enq_pct = 65;
      endcase
      if (chunk == 2) begin
        // receiver goes quiet while the sender keeps pushing
        long_hold_req = 1'b1;
        steady_mode   = 1'b1;
      end
      if (chunk == 5) wait_drained();
      if (chunk == 8) steady_mode = 1'b1;
      for (k = 0; k < CHUNK_OPS; k++) begin
        if ($urandom_range(99) < enq_pct)
          send_op(spq_pkg::FUNC_ENQ, pick_prio(), pick_payload());
        else
          send_op(spq_pkg::FUNC_DEQ, spq_pkg::PRIO_BITS'($urandom_range(255)), $urandom());
      end
      steady_mode = 1'b0;
    end

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.owed.size() == 0)
      $display("tb_stable_priority_queue_core: PASS");
    else
      $display("tb_stable_priority_queue_core: FAIL");
    $finish;
  end

endmodule
